// File: rtl/ftt_pkg.sv
// shared types and constants of the forest tree table keeper
`default_nettype none

package ftt_pkg;

   // widest fields over the supported parameter ranges
   localparam int TREE_MAX_W  = 6;
   localparam int ADDR_MAX_W  = 22;
   localparam int WORD_W      = 16;
   localparam int FIELD_W     = 8;
   localparam int TOTAL_W     = 9;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_INIT,
      CMD_BG_START,
      CMD_SWAP,
      CMD_SPLIT,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic                     tree_ok;
      logic [TREE_MAX_W-1:0]    tree;
      logic                     bg_ok;
      logic [TREE_MAX_W-1:0]    bg;
      logic [ADDR_MAX_W-1:0]    node_a;
      logic                     node_ok_a;
      logic [ADDR_MAX_W-1:0]    node_b;
      logic                     node_ok_b;
      logic [ADDR_MAX_W-1:0]    node_c;
      logic                     node_ok_c;
      logic [ADDR_MAX_W-1:0]    leaf_a;
      logic                     leaf_ok_a;
      logic [ADDR_MAX_W-1:0]    leaf_b;
      logic                     leaf_ok_b;
      logic [FIELD_W-1:0]       attr;
      logic [FIELD_W-1:0]       fleaf;
      logic [FIELD_W-1:0]       nleaf;
      logic [FIELD_W-1:0]       maj;
      logic [FIELD_W-1:0]       class_b;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/forest_tree_table_update.sv
// top level of the forest tree table keeper
// Requests are taken when start is high and busy is low; a decode stage turns each request
// into a table command and places it in a two-entry queue, and an execution stage drains the
// queue through single-write-port node and leaf memories. Init, drift swap, reset-flag clear
// and read end after their first memory step; a background activation then writes the root
// leaf of the background tree, and a split writes the two child nodes in turn. busy is high
// while the queue is full or the memory clear pass runs. A read raises rsp_valid for one
// cycle once it has passed the queue, the command register and the result register; results
// come out in request order and are never held back.
// After reset the memories are cleared in one pass over max(TREES*NODES_PER_TREE,
// TREES*LEAVES_PER_TREE) addresses (4096 at the defaults), during which busy stays high.
`default_nettype none

module forest_tree_table_update #(
   parameter int TREES            = 8,
   parameter int FOREGROUND_TREES = 4,
   parameter int NODES_PER_TREE   = 512,
   parameter int LEAVES_PER_TREE  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [2:0]  req_tree_index,
   input  wire logic        req_training_valid,
   input  wire logic [7:0]  req_best_attribute,
   input  wire logic [7:0]  req_new_leaf,
   input  wire logic        req_split,
   input  wire logic [7:0]  req_found_leaf,
   input  wire logic [8:0]  req_node_index,
   input  wire logic        req_change_found,
   input  wire logic        req_drift_warning,
   input  wire logic [7:0]  req_majority_class,
   input  wire logic [7:0]  req_background_class,
   output logic             rsp_valid,
   output logic [15:0]      rsp_node_word,
   output logic             rsp_node_is_leaf,
   output logic             rsp_reset_pending,
   output logic [7:0]       rsp_leaf_class,
   output logic [8:0]       rsp_leaf_total,
   output logic             rsp_tree_active,
   output logic             rsp_tree_foreground
);

   ftt_pkg::cmd_type front_cmd, head_cmd;
   logic             front_keep, q_push, q_pop, q_empty, q_full, clearing;

   ftt_front #(
      .TREES            (TREES),
      .FOREGROUND_TREES (FOREGROUND_TREES),
      .NODES_PER_TREE   (NODES_PER_TREE),
      .LEAVES_PER_TREE  (LEAVES_PER_TREE)
   ) u_front (
      .req_opcode           (req_opcode),
      .req_tree_index       (req_tree_index),
      .req_training_valid   (req_training_valid),
      .req_best_attribute   (req_best_attribute),
      .req_new_leaf         (req_new_leaf),
      .req_split            (req_split),
      .req_found_leaf       (req_found_leaf),
      .req_node_index       (req_node_index),
      .req_change_found     (req_change_found),
      .req_drift_warning    (req_drift_warning),
      .req_majority_class   (req_majority_class),
      .req_background_class (req_background_class),
      .cmd                  (front_cmd),
      .cmd_keep             (front_keep)
   );

   // requests that change nothing and return nothing are dropped here
   assign busy   = q_full || clearing;
   assign q_push = start && !busy && front_keep;

   ftt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   ftt_back #(
      .TREES           (TREES),
      .NODES_PER_TREE  (NODES_PER_TREE),
      .LEAVES_PER_TREE (LEAVES_PER_TREE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (!q_empty),
      .cmd                 (head_cmd),
      .cmd_pop             (q_pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_node_word       (rsp_node_word),
      .rsp_node_is_leaf    (rsp_node_is_leaf),
      .rsp_reset_pending   (rsp_reset_pending),
      .rsp_leaf_class      (rsp_leaf_class),
      .rsp_leaf_total      (rsp_leaf_total),
      .rsp_tree_active     (rsp_tree_active),
      .rsp_tree_foreground (rsp_tree_foreground)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("request port open before the memory clear pass");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !clearing)
      else $error("result given during the memory clear pass");

endmodule

`default_nettype wire

// File: rtl/ftt_front.sv
// request decode: classifies a request and computes its table addresses
`default_nettype none

module ftt_front #(
   parameter int TREES            = 8,
   parameter int FOREGROUND_TREES = 4,
   parameter int NODES_PER_TREE   = 512,
   parameter int LEAVES_PER_TREE  = 256
) (
   input  wire logic [1:0] req_opcode,
   input  wire logic [2:0] req_tree_index,
   input  wire logic       req_training_valid,
   input  wire logic [7:0] req_best_attribute,
   input  wire logic [7:0] req_new_leaf,
   input  wire logic       req_split,
   input  wire logic [7:0] req_found_leaf,
   input  wire logic [8:0] req_node_index,
   input  wire logic       req_change_found,
   input  wire logic       req_drift_warning,
   input  wire logic [7:0] req_majority_class,
   input  wire logic [7:0] req_background_class,
   output ftt_pkg::cmd_type cmd,
   output logic            cmd_keep
);

   logic [31:0] tree_w, bg_w, node_w, child1_w, child2_w, fleaf_w, nleaf_w;
   logic [31:0] tree_node_base, bg_node_base, tree_leaf_base, bg_leaf_base;
   logic        tree_ok, bg_ok, node_ok, child1_ok, child2_ok, fleaf_ok, nleaf_ok;

   always_comb begin
      tree_w   = 32'(req_tree_index);
      // paired tree of the other half
      bg_w     = (tree_w >= 32'(FOREGROUND_TREES)) ? tree_w - 32'(FOREGROUND_TREES)
                                                   : tree_w + 32'(FOREGROUND_TREES);
      node_w   = 32'(req_node_index);
      child1_w = {node_w[30:0], 1'b0} + 32'd1;
      child2_w = {node_w[30:0], 1'b0} + 32'd2;
      fleaf_w  = 32'(req_found_leaf);
      nleaf_w  = 32'(req_new_leaf);

      tree_node_base = tree_w * 32'(NODES_PER_TREE);
      bg_node_base   = bg_w * 32'(NODES_PER_TREE);
      tree_leaf_base = tree_w * 32'(LEAVES_PER_TREE);
      bg_leaf_base   = bg_w * 32'(LEAVES_PER_TREE);

      tree_ok   = tree_w < 32'(TREES);
      bg_ok     = bg_w < 32'(TREES);
      node_ok   = node_w < 32'(NODES_PER_TREE);
      child1_ok = child1_w < 32'(NODES_PER_TREE);
      child2_ok = child2_w < 32'(NODES_PER_TREE);
      fleaf_ok  = fleaf_w < 32'(LEAVES_PER_TREE);
      nleaf_ok  = nleaf_w < 32'(LEAVES_PER_TREE);

      cmd         = '0;
      cmd.kind    = ftt_pkg::CMD_READ;
      cmd.tree_ok = tree_ok;
      cmd.tree    = tree_w[ftt_pkg::TREE_MAX_W-1:0];
      cmd.bg_ok   = bg_ok;
      cmd.bg      = bg_w[ftt_pkg::TREE_MAX_W-1:0];
      cmd.attr    = req_best_attribute;
      cmd.fleaf   = req_found_leaf;
      cmd.nleaf   = req_new_leaf;
      cmd.maj     = req_majority_class;
      cmd.class_b = req_majority_class;
      cmd_keep    = 1'b0;

      case (req_opcode)
         ftt_pkg::OP_INIT: begin
            cmd_keep      = tree_ok && (tree_w < 32'(FOREGROUND_TREES));
            cmd.kind      = ftt_pkg::CMD_INIT;
            cmd.node_a    = tree_node_base[ftt_pkg::ADDR_MAX_W-1:0];
            cmd.node_ok_a = 1'b1;
            cmd.leaf_a    = tree_leaf_base[ftt_pkg::ADDR_MAX_W-1:0];
            cmd.leaf_ok_a = 1'b1;
         end
         ftt_pkg::OP_UPDATE: begin
            cmd_keep      = req_training_valid && tree_ok;
            cmd.leaf_a    = 22'(tree_leaf_base + fleaf_w);
            cmd.leaf_ok_a = fleaf_ok;
            if (req_change_found && !req_drift_warning) begin
               cmd.kind      = ftt_pkg::CMD_BG_START;
               cmd.node_a    = bg_node_base[ftt_pkg::ADDR_MAX_W-1:0];
               cmd.node_ok_a = bg_ok;
               cmd.leaf_b    = bg_leaf_base[ftt_pkg::ADDR_MAX_W-1:0];
               cmd.leaf_ok_b = bg_ok;
               cmd.class_b   = req_background_class;
            end else if (req_change_found) begin
               cmd.kind = ftt_pkg::CMD_SWAP;
            end else if (req_split) begin
               cmd.kind      = ftt_pkg::CMD_SPLIT;
               cmd.node_a    = 22'(tree_node_base + node_w);
               cmd.node_ok_a = node_ok;
               cmd.node_b    = 22'(tree_node_base + child1_w);
               cmd.node_ok_b = child1_ok;
               cmd.node_c    = 22'(tree_node_base + child2_w);
               cmd.node_ok_c = child2_ok;
               cmd.leaf_b    = 22'(tree_leaf_base + nleaf_w);
               cmd.leaf_ok_b = nleaf_ok;
            end else begin
               cmd.kind = ftt_pkg::CMD_CLEAR;
            end
         end
         ftt_pkg::OP_READ: begin
            cmd_keep      = 1'b1;
            cmd.kind      = ftt_pkg::CMD_READ;
            cmd.node_a    = 22'(tree_node_base + node_w);
            cmd.node_ok_a = tree_ok && node_ok;
            cmd.leaf_a    = 22'(tree_leaf_base + fleaf_w);
            cmd.leaf_ok_a = tree_ok && fleaf_ok;
         end
         default: begin
            cmd_keep = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ftt_queue.sv
// short command queue between request decode and table execution
`default_nettype none

module ftt_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ftt_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output ftt_pkg::cmd_type      head_cmd,
   output logic                  empty,
   output logic                  full
);

   localparam int DEPTH = ftt_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ftt_pkg::cmd_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_cmd = slot_ff[rd_ptr_ff];
   assign empty    = count_ff == '0;
   assign full     = count_ff == CNT_W'(DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ftt_back.sv
// table execution: node and leaf memories, per-tree flags and read results
`default_nettype none

module ftt_back #(
   parameter int TREES           = 8,
   parameter int NODES_PER_TREE  = 512,
   parameter int LEAVES_PER_TREE = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire ftt_pkg::cmd_type  cmd,
   output logic                   cmd_pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   output logic [15:0]            rsp_node_word,
   output logic                   rsp_node_is_leaf,
   output logic                   rsp_reset_pending,
   output logic [7:0]             rsp_leaf_class,
   output logic [8:0]             rsp_leaf_total,
   output logic                   rsp_tree_active,
   output logic                   rsp_tree_foreground
);

   localparam int NODE_DEPTH = TREES * NODES_PER_TREE;
   localparam int LEAF_DEPTH = TREES * LEAVES_PER_TREE;
   localparam int NODE_AW    = $clog2(NODE_DEPTH);
   localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
   localparam int CLR_DEPTH  = (NODE_DEPTH > LEAF_DEPTH) ? NODE_DEPTH : LEAF_DEPTH;
   localparam int CLR_W      = $clog2(CLR_DEPTH + 1);
   localparam int TREE_W     = $clog2(TREES);
   localparam int WORD_W     = ftt_pkg::WORD_W;
   localparam int CLASS_W    = ftt_pkg::FIELD_W;
   localparam int TOTAL_W    = ftt_pkg::TOTAL_W;

   function automatic logic [1:0] last_step_of(input ftt_pkg::cmd_kind_type kind);
      logic [1:0] last;
      case (kind)
         ftt_pkg::CMD_SPLIT:    last = 2'd2;
         ftt_pkg::CMD_BG_START: last = 2'd1;
         default:               last = 2'd0;
      endcase
      return last;
   endfunction

   logic [WORD_W-1:0]  node_mem  [NODE_DEPTH];
   logic               flag_mem  [NODE_DEPTH];
   logic [CLASS_W-1:0] class_mem [LEAF_DEPTH];
   logic               reset_mem [LEAF_DEPTH];

   logic               clearing_ff, clearing_in;
   logic [CLR_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic               active_ff, active_in;
   logic [1:0]         step_ff, step_in;
   ftt_pkg::cmd_type   cmd_ff;
   logic               last_step;

   logic [TOTAL_W-1:0] leaf_count_ff [TREES];
   logic               active_flag_ff [TREES];
   logic               fg_flag_ff [TREES];

   logic [WORD_W-1:0]  node_q_ff;
   logic               flag_q_ff, reset_q_ff;
   logic [CLASS_W-1:0] class_q_ff;
   logic               rsp_valid_ff, rsp_node_ok_ff, rsp_leaf_ok_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_active_ff, rsp_fg_ff;

   logic               node_we, flag_we, flag_wdata;
   logic [NODE_AW-1:0] node_waddr;
   logic [WORD_W-1:0]  node_wdata;
   logic               class_we, reset_we, reset_wdata;
   logic [LEAF_AW-1:0] leaf_waddr;
   logic [CLASS_W-1:0] class_wdata;
   logic               read_step;
   logic [TREE_W-1:0]  tree_sel, bg_sel;

   assign tree_sel  = cmd_ff.tree[TREE_W-1:0];
   assign bg_sel    = cmd_ff.bg[TREE_W-1:0];
   assign last_step = step_ff == last_step_of(cmd_ff.kind);
   assign read_step = active_ff && (cmd_ff.kind == ftt_pkg::CMD_READ);

   // sequencer: one memory step per cycle, next command taken on the last step
   always_comb begin
      cmd_pop      = cmd_valid && !clearing_ff && (!active_ff || last_step);
      clearing_in  = clearing_ff && (clear_cnt_ff != CLR_W'(CLR_DEPTH - 1));
      clear_cnt_in = clearing_ff ? clear_cnt_ff + CLR_W'(1) : clear_cnt_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         step_in   = 2'd0;
      end else if (active_ff && last_step) begin
         active_in = 1'b0;
         step_in   = step_ff;
      end else begin
         active_in = active_ff;
         step_in   = active_ff ? step_ff + 2'd1 : step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
         active_ff    <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
   end

   // node memory write port
   always_comb begin
      node_we    = 1'b0;
      flag_we    = 1'b0;
      node_waddr = cmd_ff.node_a[NODE_AW-1:0];
      node_wdata = WORD_W'(cmd_ff.attr);
      flag_wdata = 1'b1;
      if (clearing_ff) begin
         node_waddr = clear_cnt_ff[NODE_AW-1:0];
         node_wdata = '0;
         flag_wdata = 1'b0;
         node_we    = clear_cnt_ff < CLR_W'(NODE_DEPTH);
         flag_we    = node_we;
      end else if (active_ff) begin
         case (step_ff)
            2'd0: begin
               node_we    = (cmd_ff.kind == ftt_pkg::CMD_SPLIT) && cmd_ff.node_ok_a;
               flag_we    = (cmd_ff.kind inside {ftt_pkg::CMD_INIT, ftt_pkg::CMD_BG_START,
                                                 ftt_pkg::CMD_SPLIT}) && cmd_ff.node_ok_a;
               flag_wdata = cmd_ff.kind != ftt_pkg::CMD_SPLIT;
            end
            2'd1: begin
               node_waddr = cmd_ff.node_b[NODE_AW-1:0];
               node_wdata = WORD_W'(cmd_ff.fleaf);
               node_we    = (cmd_ff.kind == ftt_pkg::CMD_SPLIT) && cmd_ff.node_ok_b;
               flag_we    = node_we;
            end
            2'd2: begin
               node_waddr = cmd_ff.node_c[NODE_AW-1:0];
               node_wdata = WORD_W'(cmd_ff.nleaf);
               node_we    = (cmd_ff.kind == ftt_pkg::CMD_SPLIT) && cmd_ff.node_ok_c;
               flag_we    = node_we;
            end
            default: begin
               node_we = 1'b0;
            end
         endcase
      end
   end

   // leaf memory write port
   always_comb begin
      class_we    = 1'b0;
      reset_we    = 1'b0;
      leaf_waddr  = cmd_ff.leaf_a[LEAF_AW-1:0];
      class_wdata = cmd_ff.maj;
      reset_wdata = cmd_ff.kind == ftt_pkg::CMD_SPLIT;
      if (clearing_ff) begin
         leaf_waddr  = clear_cnt_ff[LEAF_AW-1:0];
         class_wdata = '0;
         reset_wdata = 1'b0;
         class_we    = clear_cnt_ff < CLR_W'(LEAF_DEPTH);
         reset_we    = class_we;
      end else if (active_ff) begin
         case (step_ff)
            2'd0: begin
               class_we = (cmd_ff.kind != ftt_pkg::CMD_READ) && cmd_ff.leaf_ok_a;
               reset_we = (cmd_ff.kind inside {ftt_pkg::CMD_SPLIT, ftt_pkg::CMD_CLEAR})
                          && cmd_ff.leaf_ok_a;
            end
            2'd1: begin
               leaf_waddr  = cmd_ff.leaf_b[LEAF_AW-1:0];
               class_wdata = cmd_ff.class_b;
               reset_wdata = 1'b1;
               class_we    = (cmd_ff.kind inside {ftt_pkg::CMD_BG_START, ftt_pkg::CMD_SPLIT})
                             && cmd_ff.leaf_ok_b;
               reset_we    = class_we;
            end
            default: begin
               class_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (flag_we) begin
         flag_mem[node_waddr] <= flag_wdata;
      end
      node_q_ff <= node_mem[cmd_ff.node_a[NODE_AW-1:0]];
      flag_q_ff <= flag_mem[cmd_ff.node_a[NODE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (class_we) begin
         class_mem[leaf_waddr] <= class_wdata;
      end
      if (reset_we) begin
         reset_mem[leaf_waddr] <= reset_wdata;
      end
      class_q_ff <= class_mem[cmd_ff.leaf_a[LEAF_AW-1:0]];
      reset_q_ff <= reset_mem[cmd_ff.leaf_a[LEAF_AW-1:0]];
   end

   // per-tree flags and leaf counts change on the first step of a command
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TREES; i++) begin
            leaf_count_ff[i]  <= '0;
            active_flag_ff[i] <= 1'b0;
            fg_flag_ff[i]     <= 1'b0;
         end
      end else if (active_ff && (step_ff == 2'd0)) begin
         case (cmd_ff.kind)
            ftt_pkg::CMD_INIT: begin
               active_flag_ff[tree_sel] <= 1'b1;
               fg_flag_ff[tree_sel]     <= 1'b1;
               leaf_count_ff[tree_sel]  <= TOTAL_W'(1);
            end
            ftt_pkg::CMD_BG_START: begin
               if (cmd_ff.bg_ok) begin
                  active_flag_ff[bg_sel] <= 1'b1;
                  leaf_count_ff[bg_sel]  <= TOTAL_W'(1);
               end
            end
            ftt_pkg::CMD_SWAP: begin
               fg_flag_ff[tree_sel]     <= 1'b0;
               active_flag_ff[tree_sel] <= 1'b0;
               if (cmd_ff.bg_ok) begin
                  fg_flag_ff[bg_sel] <= 1'b1;
               end
            end
            ftt_pkg::CMD_SPLIT: begin
               leaf_count_ff[tree_sel] <= {1'b0, cmd_ff.nleaf} + TOTAL_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= read_step;
      end
   end

   always_ff @(posedge clock) begin
      if (read_step) begin
         rsp_node_ok_ff <= cmd_ff.node_ok_a;
         rsp_leaf_ok_ff <= cmd_ff.leaf_ok_a;
         rsp_total_ff   <= cmd_ff.tree_ok ? leaf_count_ff[tree_sel] : '0;
         rsp_active_ff  <= cmd_ff.tree_ok && active_flag_ff[tree_sel];
         rsp_fg_ff      <= cmd_ff.tree_ok && fg_flag_ff[tree_sel];
      end
   end

   assign clearing            = clearing_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_node_word       = rsp_node_ok_ff ? node_q_ff : '0;
   assign rsp_node_is_leaf    = rsp_node_ok_ff && flag_q_ff;
   assign rsp_reset_pending   = rsp_leaf_ok_ff && reset_q_ff;
   assign rsp_leaf_class      = rsp_leaf_ok_ff ? class_q_ff : '0;
   assign rsp_leaf_total      = rsp_total_ff;
   assign rsp_tree_active     = rsp_active_ff;
   assign rsp_tree_foreground = rsp_fg_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_forest_tree_table_update.sv
// self-checking testbench for the forest tree table keeper: directed and random requests
`timescale 1ns / 100ps

module tb_forest_tree_table_update;

   localparam int TREE_CNT = 8;
   localparam int FG_TREES = 4;
   localparam int NODES    = 512;
   localparam int LEAVES   = 256;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] tree;
      logic       valid;
      logic [7:0] attr;
      logic [7:0] nleaf;
      logic       split;
      logic [7:0] fleaf;
      logic [8:0] node;
      logic       change;
      logic       warn;
      logic [7:0] maj;
      logic [7:0] bgc;
   } table_request_type;

   typedef struct packed {
      logic [15:0] word;
      logic        is_leaf;
      logic        reset_pend;
      logic [7:0]  cls;
      logic [8:0]  total;
      logic        active;
      logic        fg;
   } table_view_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_opcode = '0;
   logic [2:0] req_tree_index = '0;
   logic       req_training_valid = 1'b0;
   logic [7:0] req_best_attribute = '0;
   logic [7:0] req_new_leaf = '0;
   logic       req_split = 1'b0;
   logic [7:0] req_found_leaf = '0;
   logic [8:0] req_node_index = '0;
   logic       req_change_found = 1'b0;
   logic       req_drift_warning = 1'b0;
   logic [7:0] req_majority_class = '0;
   logic [7:0] req_background_class = '0;
   logic        rsp_valid;
   logic [15:0] rsp_node_word;
   logic        rsp_node_is_leaf;
   logic        rsp_reset_pending;
   logic [7:0]  rsp_leaf_class;
   logic [8:0]  rsp_leaf_total;
   logic        rsp_tree_active;
   logic        rsp_tree_foreground;

   // shadow copy of the block's tables
   logic [15:0] node_word_tbl [TREE_CNT][NODES];
   logic        leaf_flag_tbl [TREE_CNT][NODES];
   logic        reset_flag_tbl [TREE_CNT][LEAVES];
   logic [7:0]  class_tbl [TREE_CNT][LEAVES];
   logic [8:0]  leaf_count_tbl [TREE_CNT];
   logic        active_tbl [TREE_CNT];
   logic        fg_tbl [TREE_CNT];

   table_request_type pending_requests[$];
   table_view_type    read_answers[$];
   table_request_type on_wire;
   int                mismatches = 0;
   int                gap_left = 0;
   int                burst_left = 0;

   forest_tree_table_update #(
      .TREES(TREE_CNT),
      .FOREGROUND_TREES(FG_TREES),
      .NODES_PER_TREE(NODES),
      .LEAVES_PER_TREE(LEAVES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_tree_index(req_tree_index),
      .req_training_valid(req_training_valid),
      .req_best_attribute(req_best_attribute),
      .req_new_leaf(req_new_leaf),
      .req_split(req_split),
      .req_found_leaf(req_found_leaf),
      .req_node_index(req_node_index),
      .req_change_found(req_change_found),
      .req_drift_warning(req_drift_warning),
      .req_majority_class(req_majority_class),
      .req_background_class(req_background_class),
      .rsp_valid(rsp_valid),
      .rsp_node_word(rsp_node_word),
      .rsp_node_is_leaf(rsp_node_is_leaf),
      .rsp_reset_pending(rsp_reset_pending),
      .rsp_leaf_class(rsp_leaf_class),
      .rsp_leaf_total(rsp_leaf_total),
      .rsp_tree_active(rsp_tree_active),
      .rsp_tree_foreground(rsp_tree_foreground)
   );

   always #10 clock = ~clock;

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic void write_node(int t, int n, logic [15:0] word, logic is_leaf);
      if (n < NODES) begin
         node_word_tbl[t][n] = word;
         leaf_flag_tbl[t][n] = is_leaf;
      end
   endfunction

   // applies one accepted request to the shadow tables, queues the answer of a read
   function automatic void apply_to_tables(table_request_type r);
      int             t;
      int             pair;
      int             n;
      table_view_type v;
      t = int'(r.tree);
      n = int'(r.node);
      pair = (t >= FG_TREES) ? t - FG_TREES : t + FG_TREES;
      case (r.opcode)
         ftt_pkg::OP_INIT: begin
            if (t < FG_TREES) begin
               active_tbl[t] = 1'b1;
               fg_tbl[t] = 1'b1;
               leaf_flag_tbl[t][0] = 1'b1;
               leaf_count_tbl[t] = 9'd1;
               class_tbl[t][0] = r.maj;
            end
         end
         ftt_pkg::OP_UPDATE: begin
            if (r.valid) begin
               class_tbl[t][r.fleaf] = r.maj;
               if (r.change && !r.warn) begin
                  // drift alarm starts the paired background tree
                  active_tbl[pair] = 1'b1;
                  leaf_flag_tbl[pair][0] = 1'b1;
                  leaf_count_tbl[pair] = 9'd1;
                  reset_flag_tbl[pair][0] = 1'b1;
                  class_tbl[pair][0] = r.bgc;
               end else if (r.change && r.warn) begin
                  fg_tbl[t] = 1'b0;
                  fg_tbl[pair] = 1'b1;
                  active_tbl[t] = 1'b0;
               end else if (r.split) begin
                  write_node(t, n, {8'd0, r.attr}, 1'b0);
                  write_node(t, 2 * n + 1, {8'd0, r.fleaf}, 1'b1);
                  write_node(t, 2 * n + 2, {8'd0, r.nleaf}, 1'b1);
                  reset_flag_tbl[t][r.fleaf] = 1'b1;
                  reset_flag_tbl[t][r.nleaf] = 1'b1;
                  class_tbl[t][r.nleaf] = r.maj;
                  leaf_count_tbl[t] = {1'b0, r.nleaf} + 9'd1;
               end else begin
                  reset_flag_tbl[t][r.fleaf] = 1'b0;
               end
            end
         end
         ftt_pkg::OP_READ: begin
            v.word = node_word_tbl[t][n];
            v.is_leaf = leaf_flag_tbl[t][n];
            v.reset_pend = reset_flag_tbl[t][r.fleaf];
            v.cls = class_tbl[t][r.fleaf];
            v.total = leaf_count_tbl[t];
            v.active = active_tbl[t];
            v.fg = fg_tbl[t];
            read_answers.push_back(v);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   task automatic add_request(logic [1:0] op, int t, bit valid, bit split, bit change, bit warn,
                              int node, int fleaf, int nleaf, int attr, int maj, int bgc);
      table_request_type r;
      r.opcode = op;
      r.tree = t[2:0];
      r.valid = valid;
      r.split = split;
      r.change = change;
      r.warn = warn;
      r.node = node[8:0];
      r.fleaf = fleaf[7:0];
      r.nleaf = nleaf[7:0];
      r.attr = attr[7:0];
      r.maj = maj[7:0];
      r.bgc = bgc[7:0];
      pending_requests.push_back(r);
   endtask

   function automatic int pick_node();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1) : $urandom_range(0, 14);
   endfunction

   function automatic int pick_leaf();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, LEAVES - 1) : $urandom_range(0, 15);
   endfunction

   // driver: bursts of requests separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            apply_to_tables(on_wire);
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            on_wire = pending_requests.pop_front();
            req_opcode <= on_wire.opcode;
            req_tree_index <= on_wire.tree;
            req_training_valid <= on_wire.valid;
            req_best_attribute <= on_wire.attr;
            req_new_leaf <= on_wire.nleaf;
            req_split <= on_wire.split;
            req_found_leaf <= on_wire.fleaf;
            req_node_index <= on_wire.node;
            req_change_found <= on_wire.change;
            req_drift_warning <= on_wire.warn;
            req_majority_class <= on_wire.maj;
            req_background_class <= on_wire.bgc;
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result is checked against the oldest predicted read
   always @(posedge clock) begin
      table_view_type want;
      if (!reset && rsp_valid) begin
         if (read_answers.size() == 0) begin
            report_mismatch("unexpected result, pending reads", 1, 0);
         end else begin
            want = read_answers.pop_front();
            if (rsp_node_word !== want.word)
               report_mismatch("node_word", int'(rsp_node_word), int'(want.word));
            if (rsp_node_is_leaf !== want.is_leaf)
               report_mismatch("node_is_leaf", int'(rsp_node_is_leaf), int'(want.is_leaf));
            if (rsp_reset_pending !== want.reset_pend)
               report_mismatch("reset_pending", int'(rsp_reset_pending),
                               int'(want.reset_pend));
            if (rsp_leaf_class !== want.cls)
               report_mismatch("leaf_class", int'(rsp_leaf_class), int'(want.cls));
            if (rsp_leaf_total !== want.total)
               report_mismatch("leaf_total", int'(rsp_leaf_total), int'(want.total));
            if (rsp_tree_active !== want.active)
               report_mismatch("tree_active", int'(rsp_tree_active), int'(want.active));
            if (rsp_tree_foreground !== want.fg)
               report_mismatch("tree_foreground", int'(rsp_tree_foreground), int'(want.fg));
         end
      end
   end

   initial begin
      int roll;
      int t;
      int n;
      int fl;
      int nl;
      bit sp;
      for (int i = 0; i < TREE_CNT; i++) begin
         leaf_count_tbl[i] = '0;
         active_tbl[i] = 1'b0;
         fg_tbl[i] = 1'b0;
         for (int j = 0; j < NODES; j++) begin
            node_word_tbl[i][j] = '0;
            leaf_flag_tbl[i][j] = 1'b0;
         end
         for (int j = 0; j < LEAVES; j++) begin
            reset_flag_tbl[i][j] = 1'b0;
            class_tbl[i][j] = '0;
         end
      end

      // directed part
      add_request(ftt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 0);
      add_request(ftt_pkg::OP_INIT, 3, 1, 1, 1, 1, 511, 255, 255, 255, 0, 255);
      // background tree: ignored
      add_request(ftt_pkg::OP_INIT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 77, 0);
      add_request(OP_UNUSED, 0, 1, 1, 0, 0, 0, 0, 0, 0, 99, 0);
      add_request(ftt_pkg::OP_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // training not valid
      add_request(ftt_pkg::OP_UPDATE, 0, 0, 1, 0, 0, 0, 0, 9, 3, 12, 0);
      add_request(ftt_pkg::OP_UPDATE, 0, 1, 1, 0, 0, 0, 0, 255, 255, 170, 0);
      add_request(ftt_pkg::OP_READ, 0, 0, 0, 0, 0, 2, 255, 0, 0, 0, 0);
      // both children dropped
      add_request(ftt_pkg::OP_UPDATE, 0, 1, 1, 0, 0, 511, 255, 1, 0, 85, 0);
      // right child dropped
      add_request(ftt_pkg::OP_UPDATE, 0, 1, 1, 0, 0, 255, 7, 8, 200, 1, 0);
      add_request(ftt_pkg::OP_READ, 0, 0, 0, 0, 0, 511, 1, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_UPDATE, 0, 1, 0, 0, 0, 0, 255, 0, 0, 44, 0);
      add_request(ftt_pkg::OP_READ, 0, 0, 0, 0, 0, 255, 255, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_UPDATE, 3, 1, 0, 1, 0, 0, 5, 0, 0, 6, 200);
      add_request(ftt_pkg::OP_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // drift after warning
      add_request(ftt_pkg::OP_UPDATE, 7, 1, 1, 1, 1, 3, 2, 4, 1, 9, 0);
      add_request(ftt_pkg::OP_READ, 7, 0, 0, 0, 0, 3, 2, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_UPDATE, 5, 1, 0, 1, 0, 0, 0, 0, 0, 0, 255);
      add_request(ftt_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_UPDATE, 0, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(ftt_pkg::OP_READ, 0, 1, 1, 1, 1, 1, 0, 255, 255, 255, 255);

      // random part: trees are grown by splits and read back, with noise mixed in
      while (pending_requests.size() < 550) begin
         roll = $urandom_range(0, 99);
         t = $urandom_range(0, TREE_CNT - 1);
         n = pick_node();
         fl = pick_leaf();
         nl = pick_leaf();
         if (roll < 8) begin
            add_request(ftt_pkg::OP_INIT, ($urandom_range(0, 4) == 0) ? t : t % FG_TREES,
                        coin(), coin(), coin(), coin(), n, fl, nl, $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (roll < 58) begin
            sp = coin();
            add_request(ftt_pkg::OP_UPDATE, t, $urandom_range(0, 9) != 0, sp,
                        $urandom_range(0, 7) == 0, coin(), n, fl, nl,
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
            // read back what the update touched
            if ($urandom_range(0, 2) != 0) begin
               if (sp && 2 * n + 2 < NODES)
                  n = 2 * n + $urandom_range(0, 2);
               add_request(ftt_pkg::OP_READ, t, coin(), coin(), coin(), coin(), n,
                           coin() ? fl : nl, $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            end
         end else if (roll < 97) begin
            add_request(ftt_pkg::OP_READ, t, coin(), coin(), coin(), coin(), n, fl, nl,
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
         end else begin
            add_request(OP_UNUSED, t, coin(), coin(), coin(), coin(), n, fl, nl,
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // sampled between edges so the driver's updates have settled
      while (pending_requests.size() != 0 || start) @(negedge clock);
      while (read_answers.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (read_answers.size() != 0) begin
         report_mismatch("outstanding reads", read_answers.size(), 0);
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // covers the clearing pass after reset and every request at its slowest
   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
